// File: sv/sorted_channel_table_core_macros.svh
// Assertion macros for the sorted channel table checker.
// Used by the checker file only; no other dependencies.
`ifndef SORTED_CHANNEL_TABLE_CORE_MACROS_SVH
`define SORTED_CHANNEL_TABLE_CORE_MACROS_SVH

// Implication checked every clock outside reset
`define SCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication checked outside reset
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: sv/sct_pkg.sv
// Package for the sorted channel table: sizes, op and status codes, payload types.
// No dependencies.
`default_nettype none
package sct_pkg;
  localparam int NumTables    = 4;
  localparam int TableDepth   = 16;
  localparam int PayloadWidth = 32;
  localparam int TblW = (NumTables > 1) ? $clog2(NumTables) : 1;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_MODIFY = 3'd2;
  localparam logic [2:0] OP_LOOKUP = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  table_select;
    logic [7:0]  frame_number;
    logic [7:0]  channel_number;
    logic [31:0] entry_payload;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  entry_index;
    logic [4:0]  entry_count;
    logic [31:0] payload_out;
    logic        table_changed;
  } rsp_t;

  typedef struct packed {
    logic [7:0]              frame;
    logic [7:0]              chan;
    logic [PayloadWidth-1:0] data;
  } entry_t;

  // Per-cycle command from the sequencer to every cell
  typedef struct packed {
    logic          load;    // capture row from memory read port
    logic          shift;   // chain moves one cell toward higher index
    logic          unshift; // chain moves one cell toward lower index
    logic          ins;     // write new entry at ins_pos
    logic          mod;     // write payload at ins_pos
    logic [IdxW:0] ins_pos;
  } cell_ctl_t;
endpackage
`default_nettype wire

// File: sv/sct_cell.sv
// One entry cell of the sorted row: holds a key/payload and compares against the probe.
// Depends on sct_pkg.
`default_nettype none
module sct_cell (
  input  wire                    clk,
  input  wire sct_pkg::cell_ctl_t ctl,
  input  wire [sct_pkg::IdxW:0]  pos,
  input  wire sct_pkg::entry_t   load_val,
  input  wire sct_pkg::entry_t   lower,
  input  wire sct_pkg::entry_t   upper,
  input  wire sct_pkg::entry_t   probe,
  output sct_pkg::entry_t        value,
  output logic                   key_eq,
  output logic                   probe_lt
);
  import sct_pkg::*;

  // compare probe key against held key
  assign key_eq   = (probe.frame == value.frame) && (probe.chan == value.chan);
  assign probe_lt = (probe.frame < value.frame) ||
                    ((probe.frame == value.frame) && (probe.chan < value.chan));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= load_val;
    end else if (ctl.ins && pos == ctl.ins_pos) begin
      value <= probe;
    end else if (ctl.mod && pos == ctl.ins_pos) begin
      value.data <= probe.data;
    end else if (ctl.shift && pos > ctl.ins_pos) begin
      value <= lower;
    end else if (ctl.unshift && pos >= ctl.ins_pos) begin
      value <= upper;
    end
  end
endmodule
`default_nettype wire

// File: sv/sorted_channel_table_core.sv
// Sequence after the accepting edge: clear, an unused op or an absent table skip the row load
// and go straight to evaluate and response; a search that changes nothing loads the row,
// evaluates and responds; a change also writes rows back from position 0 up past the last one changed.
// One transaction at a time; busy is high meanwhile and start is taken again in the done cycle.
// Reset clears counts, changed flags and control; entry memory is not cleared.
// The receiver cannot stall: the result strobe lasts one cycle. Depends on sct_pkg, sct_cell.
`default_nettype none
module sorted_channel_table_core (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire sct_pkg::cmd_t cmd,
  output logic              busy,
  output logic              done,
  output sct_pkg::rsp_t     rsp
);
  import sct_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  localparam int AddrW = TblW + IdxW;

  logic [2:0]  state;
  cmd_t        req;
  entry_t      probe;
  logic [IdxW:0] cnt_i;   // load / write-back counter
  logic [CntW-1:0] counts [NumTables];
  logic        chg [NumTables];
  logic        bad_tbl;
  logic [TblW-1:0] tsel;

  // entry memory: one write, one registered read
  entry_t mem [NumTables*TableDepth];
  entry_t mem_q;
  logic   mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;

  cell_ctl_t ctl;
  entry_t    vals [TableDepth];
  logic [TableDepth-1:0] eqv, ltv;

  assign tsel    = req.table_select[TblW-1:0];
  assign bad_tbl = ({30'd0, req.table_select} >= NumTables);
  assign probe   = '{frame: req.frame_number, chan: req.channel_number,
                     data: req.entry_payload[PayloadWidth-1:0]};
  assign busy    = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= vals[cnt_i[IdxW-1:0]];
    mem_q <= mem[mem_ra];
  end
  assign mem_ra = {tsel, cnt_i[IdxW-1:0]};
  assign mem_wa = {tsel, cnt_i[IdxW-1:0]};

  // row of cells
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    localparam logic [IdxW:0] Pos = (IdxW+1)'(g);
    entry_t lo, hi;
    logic ld;
    cell_ctl_t c;
    if (g == 0) begin : g_lo
      assign lo = '0;
    end else begin : g_lom
      assign lo = vals[g-1];
    end
    if (g == TableDepth-1) begin : g_hi
      assign hi = '0;
    end else begin : g_him
      assign hi = vals[g+1];
    end
    assign ld = (state == S_LOAD) && (cnt_i == Pos + 1);
    always_comb begin
      c = ctl;
      c.load = ld;
    end
    sct_cell u_cell (
      .clk(clk), .ctl(c), .pos(Pos), .load_val(mem_q), .lower(lo), .upper(hi),
      .probe(probe), .value(vals[g]), .key_eq(eqv[g]), .probe_lt(ltv[g])
    );
  end

  // search over valid cells (independent compares, priority pick)
  logic [CntW-1:0] n;
  logic            found, gt_found;
  logic [IdxW:0]   fpos, gpos;
  assign n = counts[tsel];
  always_comb begin
    found = 1'b0; gt_found = 1'b0; fpos = '0; gpos = (IdxW+1)'(n);
    for (int k = TableDepth-1; k >= 0; k--) begin
      if (k < int'(n)) begin
        if (eqv[k]) begin found = 1'b1; fpos = (IdxW+1)'(k); end
        if (ltv[k] || eqv[k]) begin gt_found = 1'b1; gpos = (IdxW+1)'(k); end
      end
    end
  end

  // sequencer
  logic [IdxW:0] wb_len;
  always_ff @(posedge clk) begin
    ctl.shift <= 1'b0; ctl.unshift <= 1'b0; ctl.ins <= 1'b0; ctl.mod <= 1'b0;
    ctl.load <= 1'b0;
    done <= 1'b0;
    mem_we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      for (int t = 0; t < NumTables; t++) begin counts[t] <= '0; chg[t] <= 1'b0; end
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          req <= cmd; cnt_i <= '0;
          state <= S_LOAD;
        end
        S_LOAD: begin
          // read pipeline: address cnt_i, data lands in mem_q on the next cycle
          if (bad_tbl || req.op == OP_CLEAR || req.op > OP_LOOKUP) begin
            state <= S_EVAL;
          end else if (cnt_i == (IdxW+1)'(TableDepth)) begin
            state <= S_EVAL;
          end else begin
            cnt_i <= cnt_i + 1'b1;
          end
        end
        S_EVAL: begin
          rsp <= '0; cnt_i <= '0;
          rsp.entry_count   <= 5'(counts[tsel]);
          rsp.table_changed <= chg[tsel];
          state <= S_RESP;
          if (bad_tbl) begin
            rsp.status <= ST_MISSING; rsp.entry_count <= '0; rsp.table_changed <= 1'b0;
          end else begin
            unique case (req.op)
              OP_ADD: begin
                if (gt_found && eqv[gpos[IdxW-1:0]]) begin
                  rsp.status <= ST_DUP; rsp.entry_index <= 5'(gpos);
                end else if (n >= CntW'(TableDepth)) begin
                  rsp.status <= ST_FULL;
                end else begin
                  ctl.shift <= 1'b1; ctl.ins <= 1'b1; ctl.ins_pos <= gpos;
                  counts[tsel] <= n + 1'b1; chg[tsel] <= 1'b1;
                  rsp.entry_index <= 5'(gpos); rsp.entry_count <= 5'(n + 1'b1);
                  rsp.table_changed <= 1'b1;
                  wb_len <= (IdxW+1)'(n); state <= S_WB;
                end
              end
              OP_REMOVE, OP_MODIFY, OP_LOOKUP: begin
                if (!found) begin
                  rsp.status <= ST_MISSING;
                end else begin
                  rsp.entry_index <= 5'(fpos);
                  if (req.op == OP_LOOKUP) begin
                    rsp.payload_out <= 32'(vals[fpos[IdxW-1:0]].data);
                  end else if (req.op == OP_MODIFY) begin
                    ctl.mod <= 1'b1; ctl.ins_pos <= fpos; chg[tsel] <= 1'b1;
                    rsp.table_changed <= 1'b1;
                    wb_len <= fpos; state <= S_WB;
                  end else begin
                    ctl.unshift <= 1'b1; ctl.ins_pos <= fpos; chg[tsel] <= 1'b1;
                    counts[tsel] <= n - 1'b1; rsp.entry_count <= 5'(n - 1'b1);
                    rsp.table_changed <= 1'b1;
                    wb_len <= (IdxW+1)'(n - 1'b1); state <= S_WB;
                  end
                end
              end
              OP_CLEAR: begin
                counts[tsel] <= '0; chg[tsel] <= 1'b0;
                rsp.entry_count <= '0; rsp.table_changed <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_WB: begin
          // write cells back, positions 0..wb_len and the one after (from cell value after update)
          if (cnt_i > wb_len || cnt_i == (IdxW+1)'(TableDepth)) begin
            state <= S_RESP;
          end else begin
            mem_we <= 1'b1;
          end
          if (mem_we) cnt_i <= cnt_i + 1'b1;
        end
        S_RESP: begin
          done <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/sct_checker.sv
// Port-level checker for sorted_channel_table_core, bound into sorted_channel_table_core.
// Depends on sct_pkg and the macros header.
`default_nettype none
`include "sorted_channel_table_core_macros.svh"
module sct_checker (
  input wire               clk,
  input wire               rst,
  input wire               start,
  input wire               busy,
  input wire               done,
  input wire sct_pkg::rsp_t rsp
);
  import sct_pkg::*;
  `SCT_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `SCT_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `SCT_ASSERT_IMP(a_count_rng, clk, rst, done, rsp.entry_count <= 5'(TableDepth))
  `SCT_ASSERT_IMP(a_pay_zero, clk, rst, done && rsp.status != ST_OK, rsp.payload_out == '0)
endmodule
bind sorted_channel_table_core sct_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire

// File: bench/tb_sorted_channel_table_core.sv
// Testbench for sorted_channel_table_core: random and directed table edits,
// checked against a behavioural copy of the sorted tables. Depends on sct_pkg.
`timescale 1ns / 1ps
module tb_sorted_channel_table_core;
  import sct_pkg::*;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  cmd_t  cmd = '0;
  logic  busy;
  logic  done;
  rsp_t  rsp;

  sorted_channel_table_core i_dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the tables
  entry_t     shadow_entries[NumTables][TableDepth];
  int         shadow_counts[NumTables];
  logic       shadow_changed[NumTables];

  cmd_t       pending_cmds[$];
  rsp_t       expected_rsps[$];
  int         errors = 0;
  int         gap_left = 0;
  int         burst_left = 0;
  logic       stim_done = 1'b0;

  // Applies one command to the shadow tables and returns the expected response
  function automatic rsp_t apply_table_op(cmd_t c);
    rsp_t r;
    int t, n, pos, i;
    logic hit;
    r = '0;
    t = int'(c.table_select);
    if (t >= NumTables) begin
      r.status = ST_MISSING;
      return r;
    end
    n = shadow_counts[t];
    pos = 0;
    hit = 1'b0;
    for (i = 0; i < n; i++) begin
      if (shadow_entries[t][i].frame == c.frame_number &&
          shadow_entries[t][i].chan == c.channel_number) begin
        pos = i;
        hit = 1'b1;
        break;
      end
    end
    r.status = ST_OK;
    case (c.op)
      OP_ADD: begin
        if (hit) begin
          r.status = ST_DUP;
          r.entry_index = 5'(pos);
        end else if (n >= TableDepth) begin
          r.status = ST_FULL;
        end else begin
          pos = n;
          for (i = 0; i < n; i++) begin
            if ({c.frame_number, c.channel_number} <
                {shadow_entries[t][i].frame, shadow_entries[t][i].chan}) begin
              pos = i;
              break;
            end
          end
          for (i = n; i > pos; i--) shadow_entries[t][i] = shadow_entries[t][i-1];
          shadow_entries[t][pos] = '{c.frame_number, c.channel_number,
                                     c.entry_payload};
          shadow_counts[t] = n + 1;
          shadow_changed[t] = 1'b1;
          r.entry_index = 5'(pos);
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < n; i++) shadow_entries[t][i] = shadow_entries[t][i+1];
          shadow_counts[t] = n - 1;
          shadow_changed[t] = 1'b1;
          r.entry_index = 5'(pos);
        end else r.status = ST_MISSING;
      end
      OP_MODIFY: begin
        if (hit) begin
          shadow_entries[t][pos].data = c.entry_payload;
          shadow_changed[t] = 1'b1;
          r.entry_index = 5'(pos);
        end else r.status = ST_MISSING;
      end
      OP_LOOKUP: begin
        if (hit) begin
          r.entry_index = 5'(pos);
          r.payload_out = shadow_entries[t][pos].data;
        end else r.status = ST_MISSING;
      end
      OP_CLEAR: begin
        shadow_counts[t] = 0;
        shadow_changed[t] = 1'b0;
      end
      default: ;
    endcase
    r.entry_count = 5'(shadow_counts[t]);
    r.table_changed = shadow_changed[t];
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] op, int t, int fr, int ch,
                                    logic [31:0] pay);
    cmd_t c;
    c.op = op;
    c.table_select = 2'(t);
    c.frame_number = 8'(fr);
    c.channel_number = 8'(ch);
    c.entry_payload = pay;
    return c;
  endfunction

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    cmd_t next_cmd;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !busy) && start) begin
      // hold the current transaction until accepted
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_cmds.size() > 0) begin
      next_cmd = pending_cmds.pop_front();
      cmd <= next_cmd;
      expected_rsps.push_back(apply_table_op(next_cmd));
      start <= 1'b1;
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
      end else burst_left <= burst_left - 1;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: every strobe must match the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && done) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected response status=%0d", rsp.status);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status); errors++;
        end
        if (rsp.entry_index !== e.entry_index) begin
          $error("entry_index exp %0d got %0d", e.entry_index, rsp.entry_index);
          errors++;
        end
        if (rsp.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, rsp.entry_count);
          errors++;
        end
        if (rsp.payload_out !== e.payload_out) begin
          $error("payload_out exp %h got %h", e.payload_out, rsp.payload_out);
          errors++;
        end
        if (rsp.table_changed !== e.table_changed) begin
          $error("table_changed exp %0d got %0d", e.table_changed, rsp.table_changed);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int k, t, fr, ch, r;
    logic [2:0] op;
    for (k = 0; k < NumTables; k++) begin
      shadow_counts[k] = 0;
      shadow_changed[k] = 1'b0;
    end
    // Directed: key extremes, duplicate, missing, full table, clear, unused ops
    pending_cmds.push_back(make_cmd(OP_LOOKUP, 0, 0, 0, 32'h0));
    pending_cmds.push_back(make_cmd(OP_ADD, 0, 255, 255, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(OP_ADD, 0, 0, 0, 32'h0));
    pending_cmds.push_back(make_cmd(OP_ADD, 0, 0, 0, 32'h1234_5678));
    pending_cmds.push_back(make_cmd(OP_LOOKUP, 0, 255, 255, 32'h0));
    pending_cmds.push_back(make_cmd(OP_MODIFY, 0, 0, 0, 32'hA5A5_5A5A));
    pending_cmds.push_back(make_cmd(OP_MODIFY, 0, 1, 1, 32'h1));
    pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 9, 9, 32'h0));
    pending_cmds.push_back(make_cmd(OP_REMOVE, 0, 0, 0, 32'h0));
    pending_cmds.push_back(make_cmd(3'd5, 0, 0, 0, 32'h0));
    pending_cmds.push_back(make_cmd(3'd6, 1, 0, 0, 32'h0));
    pending_cmds.push_back(make_cmd(3'd7, 3, 255, 255, 32'hFFFF_FFFF));
    for (k = 0; k < TableDepth + 1; k++)
      pending_cmds.push_back(make_cmd(OP_ADD, 3, 16 - k, k, $urandom()));
    pending_cmds.push_back(make_cmd(OP_CLEAR, 3, 0, 0, 32'h0));
    // Random: keys from a narrow pool so hits and full tables are common
    for (k = 0; k < 1020; k++) begin
      r = $urandom_range(0, 99);
      op = (r < 35) ? OP_ADD : (r < 55) ? OP_REMOVE : (r < 70) ? OP_MODIFY :
           (r < 92) ? OP_LOOKUP : (r < 96) ? OP_CLEAR : 3'($urandom_range(5, 7));
      t = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) begin
        fr = $urandom_range(0, 255);
        ch = $urandom_range(0, 255);
      end else begin
        fr = $urandom_range(0, 4) * 63;
        ch = $urandom_range(0, 4) * 63 + (($urandom_range(0, 3) == 0) ? 1 : 0);
      end
      pending_cmds.push_back(make_cmd(op, t, fr, ch, $urandom()));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (!start && expected_rsps.size() == 0);
    repeat (2 * TableDepth + 10) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
